/* rtl/nnis_pkg.sv */
`timescale 1ns / 1ps

package nnis_pkg;

    localparam int ACC_W       = 25;
    localparam int DIM_W       = 13;
    localparam int CNT_W       = 12;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 25;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 4'd3;

    localparam logic [DIM_W-1:0] DST_WIDTH_RST  = 13'd1;
    localparam logic [DIM_W-1:0] DST_HEIGHT_RST = 13'd1;
    localparam logic [ACC_W-1:0] STEP_X_RST     = 25'd65537;
    localparam logic [ACC_W-1:0] STEP_Y_RST     = 25'd65537;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_FETCH = 1'b1
    } t_func;

    typedef struct packed {
        logic eor;
        logic eof;
    } t_flags;

endpackage

/* rtl/nnis_ram.sv */
`timescale 1ns / 1ps

module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/nnis_queue.sv */
`timescale 1ns / 1ps

module nnis_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/nnis_front.sv */
`timescale 1ns / 1ps

module nnis_front import nnis_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRACTION_BITS  = 16,
    parameter int PIXEL_BITS     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [7:0]            i_src_col,
    input  logic [7:0]            i_src_row,
    input  logic [31:0]           i_pixel_in,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output logic                  o_cmd_wr,
    output logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0] o_cmd_addr,
    output logic [PIXEL_BITS-1:0] o_cmd_wdata,
    output t_flags                o_cmd_flags
);

    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int AW    = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int CMP_W = 18;

    logic [DIM_W-1:0] r_dst_width, r_dst_height;
    logic [ACC_W-1:0] r_step_x, r_step_y;
    logic [ACC_W-1:0] r_col_acc, r_row_acc, n_col_acc, n_row_acc;
    logic [CNT_W-1:0] r_col_cnt, r_row_cnt, n_col_cnt, n_row_cnt;

    logic [CMP_W-1:0] w_fcol, w_frow, w_wcol, w_wrow;
    logic [CNT_W-1:0] w_w_last, w_h_last;
    logic             w_eor, w_eof, w_in_range, w_accept, w_fetch;
    logic [AW-1:0]    w_faddr, w_waddr;

    function automatic logic [CMP_W-1:0] sat_idx(input logic [ACC_W-1:0] acc,
                                                 input int limit);
        logic [CMP_W-1:0] i;
        logic [CMP_W-1:0] lim;
        i   = CMP_W'(acc >> FRACTION_BITS);
        lim = CMP_W'(limit);
        return (i >= lim) ? lim - 1'b1 : i;
    endfunction

    function automatic logic [CNT_W-1:0] last_pos(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > DIM_MAX) begin
            return CNT_W'(DIM_MAX - 1'b1);
        end
        return CNT_W'(v - 1'b1);
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                  input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign w_accept    = i_valid && o_ready;
    assign w_fetch     = w_accept && (i_func == FUNC_FETCH);

    // fetch address
    assign w_fcol  = sat_idx(r_col_acc, MAX_SRC_WIDTH);
    assign w_frow  = sat_idx(r_row_acc, MAX_SRC_HEIGHT);
    assign w_faddr = AW'(w_frow[YW-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(w_fcol[XW-1:0]);

    // source write address
    assign w_wcol     = CMP_W'(i_src_col);
    assign w_wrow     = CMP_W'(i_src_row);
    assign w_in_range = (w_wcol < CMP_W'(MAX_SRC_WIDTH)) && (w_wrow < CMP_W'(MAX_SRC_HEIGHT));
    assign w_waddr    = AW'(w_wrow[YW-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(w_wcol[XW-1:0]);

    assign w_w_last = last_pos(r_dst_width);
    assign w_h_last = last_pos(r_dst_height);
    assign w_eor    = (r_col_cnt >= w_w_last);
    assign w_eof    = w_eor && (r_row_cnt >= w_h_last);

    assign o_push      = w_accept && ((i_func == FUNC_FETCH) || w_in_range);
    assign o_cmd_wr    = (i_func == FUNC_WRITE);
    assign o_cmd_addr  = (i_func == FUNC_FETCH) ? w_faddr : w_waddr;
    assign o_cmd_wdata = i_pixel_in[PIXEL_BITS-1:0];
    assign o_cmd_flags = (i_func == FUNC_FETCH) ? t_flags'{eor: w_eor, eof: w_eof} : '0;

    always_comb begin
        n_col_acc = r_col_acc;
        n_row_acc = r_row_acc;
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (w_fetch) begin
            if (w_eor) begin
                n_col_acc = '0;
                n_col_cnt = '0;
                if (w_eof) begin
                    n_row_acc = '0;
                    n_row_cnt = '0;
                end else begin
                    n_row_acc = sat_add(r_row_acc, r_step_y);
                    n_row_cnt = r_row_cnt + 1'b1;
                end
            end else begin
                n_col_acc = sat_add(r_col_acc, r_step_x);
                n_col_cnt = r_col_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_acc <= '0;
            r_row_acc <= '0;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            r_col_acc <= n_col_acc;
            r_row_acc <= n_row_acc;
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_width  <= DST_WIDTH_RST;
            r_dst_height <= DST_HEIGHT_RST;
            r_step_x     <= STEP_X_RST;
            r_step_y     <= STEP_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DIM_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DIM_W-1:0];
                CFG_STEP_X:     r_step_x     <= i_cfg_data[ACC_W-1:0];
                CFG_STEP_Y:     r_step_y     <= i_cfg_data[ACC_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/nnis_back.sv */
`timescale 1ns / 1ps

module nnis_back import nnis_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int PIXEL_BITS     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic                  i_q_wr,
    input  logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0] i_q_addr,
    input  logic [PIXEL_BITS-1:0] i_q_wdata,
    input  t_flags                i_q_flags,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_out_pixel,
    output logic                  o_end_of_row,
    output logic                  o_end_of_frame
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    logic                  r_pend;
    t_flags                r_pend_flags;
    logic                  r_ov [2];
    logic [PIXEL_BITS-1:0] r_od [2];
    t_flags                r_of [2];

    logic                  w_take, w_room, w_rd;
    logic [2:0]            w_used;
    logic [PIXEL_BITS-1:0] w_rdata;

    // two output slots; a read issues only when a slot is sure to be free
    assign w_take  = r_ov[0] && i_ready;
    assign w_used  = 3'({2'b0, r_ov[0]}) + 3'({2'b0, r_ov[1]}) + 3'({2'b0, r_pend});
    assign w_room  = w_used < (3'd2 + 3'({2'b0, w_take}));
    assign o_q_pop = i_q_valid && (i_q_wr || w_room);
    assign w_rd    = o_q_pop && !i_q_wr;

    nnis_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (o_q_pop && i_q_wr),
        .i_re    (w_rd),
        .i_addr  (i_q_addr),
        .i_wdata (i_q_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_ov[0] <= 1'b0;
            r_ov[1] <= 1'b0;
        end else begin
            r_pend <= w_rd;
            case ({w_take, r_pend})
                2'b11: begin
                    r_ov[0] <= 1'b1;
                    r_ov[1] <= r_ov[1];
                end
                2'b10: begin
                    r_ov[0] <= r_ov[1];
                    r_ov[1] <= 1'b0;
                end
                2'b01: begin
                    r_ov[0] <= 1'b1;
                    r_ov[1] <= r_ov[0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_flags <= i_q_flags;
        case ({w_take, r_pend})
            2'b11: begin
                if (r_ov[1]) begin
                    r_od[0] <= r_od[1];
                    r_of[0] <= r_of[1];
                    r_od[1] <= w_rdata;
                    r_of[1] <= r_pend_flags;
                end else begin
                    r_od[0] <= w_rdata;
                    r_of[0] <= r_pend_flags;
                end
            end
            2'b10: begin
                r_od[0] <= r_od[1];
                r_of[0] <= r_of[1];
            end
            2'b01: begin
                if (r_ov[0]) begin
                    r_od[1] <= w_rdata;
                    r_of[1] <= r_pend_flags;
                end else begin
                    r_od[0] <= w_rdata;
                    r_of[0] <= r_pend_flags;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_ov[0];
    assign o_out_pixel    = 32'(r_od[0]);
    assign o_end_of_row   = r_of[0].eor;
    assign o_end_of_frame = r_of[0].eof;

endmodule

/* rtl/nearest_neighbor_image_scaler_unit.sv */
`timescale 1ns / 1ps

// Nearest-neighbor scaler. Words with func = write store one source pixel at
// (src_row, src_col); words with func = fetch return the next target pixel in
// raster order, taken at the 9.16 (FRACTION_BITS) accumulator position, with
// end-of-row and end-of-frame flags. Writes return nothing. The front end takes
// one word per cycle and queues it unless the queue is full; the back end does
// one frame-store access per cycle on a single-port RAM, reads waiting for a free
// output slot, so the sustained rate is one word per clock while the output is
// not stalled. A fetched pixel passes the queue, the RAM read and an output slot
// on its way out. Write the size and step registers only while the unit is idle.

module nearest_neighbor_image_scaler_unit import nnis_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRACTION_BITS  = 16,
    parameter int PIXEL_BITS     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [7:0]            i_src_col,
    input  logic [7:0]            i_src_row,
    input  logic [31:0]           i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_out_pixel,
    output logic                  o_end_of_row,
    output logic                  o_end_of_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int QW = 1 + $bits(t_flags) + AW + PIXEL_BITS;

    logic                  w_push, w_cmd_wr, w_q_full, w_q_valid, w_q_pop;
    logic [AW-1:0]         w_cmd_addr;
    logic [PIXEL_BITS-1:0] w_cmd_wdata;
    t_flags                w_cmd_flags;
    logic [QW-1:0]         w_q_in, w_q_out;

    nnis_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRACTION_BITS  (FRACTION_BITS),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_src_col   (i_src_col),
        .i_src_row   (i_src_row),
        .i_pixel_in  (i_pixel_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd_wr    (w_cmd_wr),
        .o_cmd_addr  (w_cmd_addr),
        .o_cmd_wdata (w_cmd_wdata),
        .o_cmd_flags (w_cmd_flags)
    );

    assign w_q_in = {w_cmd_wr, w_cmd_flags, w_cmd_addr, w_cmd_wdata};

    nnis_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    nnis_back #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_wr         (w_q_out[QW-1]),
        .i_q_addr       (w_q_out[AW+PIXEL_BITS-1:PIXEL_BITS]),
        .i_q_wdata      (w_q_out[PIXEL_BITS-1:0]),
        .i_q_flags      (t_flags'(w_q_out[QW-2:AW+PIXEL_BITS])),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_pixel    (o_out_pixel),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

/* tb/sv/nearest_neighbor_image_scaler_unit_tb.sv */
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_unit_tb import nnis_pkg::*; ();

    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 12;
    localparam int TOTAL_WORDS   = 950;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int HOLD_CYCLES   = 250;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 4'hF;

    typedef struct packed {
        logic [31:0] pixel;
        logic        eor;
        logic        eof;
    } t_scaled_px;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic                  i_func         = 1'b0;
    logic [7:0]            i_src_col      = '0;
    logic [7:0]            i_src_row      = '0;
    logic [31:0]           i_pixel_in     = '0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic [31:0]           o_out_pixel;
    logic                  o_end_of_row;
    logic                  o_end_of_frame;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    nearest_neighbor_image_scaler_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_src_col      (i_src_col),
        .i_src_row      (i_src_row),
        .i_pixel_in     (i_pixel_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_pixel    (o_out_pixel),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // scaler shadow state
    logic [31:0]       src_img  [0:65535];
    bit                src_seen [0:65535];
    logic [ACC_W-1:0]  col_acc  = '0;
    logic [ACC_W-1:0]  row_acc  = '0;
    logic [CNT_W-1:0]  col_cnt  = '0;
    logic [CNT_W-1:0]  row_cnt  = '0;
    logic [DIM_W-1:0]  dst_w    = DST_WIDTH_RST;
    logic [DIM_W-1:0]  dst_h    = DST_HEIGHT_RST;
    logic [ACC_W-1:0]  step_x_r = STEP_X_RST;
    logic [ACC_W-1:0]  step_y_r = STEP_Y_RST;

    t_scaled_px expected_px[$];
    t_scaled_px head_px;
    int         errors      = 0;
    int         cycle_cnt   = 0;
    int         words_sent  = 0;
    bit         steady      = 1'b0;
    bit         rx_hold_req = 1'b0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        if (d == '0) return 13'd1;
        if (d > DIM_MAX) return DIM_MAX;
        return d;
    endfunction

    function automatic logic [ACC_W-1:0] sat_step(input logic [ACC_W-1:0] a,
                                                  input logic [ACC_W-1:0] s);
        logic [ACC_W:0] sum;
        sum = {1'b0, a} + {1'b0, s};
        return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    endfunction

    function automatic logic [15:0] fetch_addr();
        logic [8:0] cx;
        logic [8:0] ry;
        cx = col_acc[ACC_W-1:FRAC_BITS];
        ry = row_acc[ACC_W-1:FRAC_BITS];
        if (cx > 9'd255) cx = 9'd255;
        if (ry > 9'd255) ry = 9'd255;
        return {ry[7:0], cx[7:0]};
    endfunction

    function automatic void advance_scan();
        t_scaled_px       px;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        w = eff_dim(dst_w);
        h = eff_dim(dst_h);
        px.pixel = src_img[fetch_addr()];
        px.eor   = {1'b0, col_cnt} >= w - 13'd1;
        px.eof   = px.eor && ({1'b0, row_cnt} >= h - 13'd1);
        if (px.eor) begin
            col_cnt = '0;
            col_acc = '0;
            if (px.eof) begin
                row_cnt = '0;
                row_acc = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
                row_acc = sat_step(row_acc, step_y_r);
            end
        end else begin
            col_cnt = col_cnt + 1'b1;
            col_acc = sat_step(col_acc, step_x_r);
        end
        expected_px.push_back(px);
    endfunction

    function automatic logic [ACC_W-1:0] rand_dim_val();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 8) return ACC_W'($urandom_range(4097, 8191));
        if (r < 10) return {12'd0, DIM_MAX};
        if (r < 12) return {12'($urandom_range(1, 4095)), 13'd20};
        return ACC_W'($urandom_range(1, 24));
    endfunction

    function automatic logic [ACC_W-1:0] rand_step(input logic [ACC_W-1:0] dim);
        int r;
        int src_span;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        if (r < 28) return ACC_W'($urandom());
        src_span = $urandom_range(1, 256);
        return ACC_W'((65536 * src_span) / eff_dim(dim[DIM_W-1:0]) + 1);
    endfunction

    task automatic send_word(input t_func f, input logic [7:0] col, input logic [7:0] row,
                             input logic [31:0] pix);
        int gap;
        gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= f;
        i_src_col  <= col;
        i_src_row  <= row;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        if (f == FUNC_WRITE) begin
            src_img[{row, col}]  = pix;
            src_seen[{row, col}] = 1'b1;
        end else begin
            advance_scan();
        end
    endtask

    // load the source pixel the next fetch lands on if it was never written
    task automatic fetch_pixel();
        logic [15:0] a;
        a = fetch_addr();
        if (!src_seen[a]) send_word(FUNC_WRITE, a[7:0], a[15:8], $urandom());
        send_word(FUNC_FETCH, 8'($urandom()), 8'($urandom()), $urandom());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DST_WIDTH:  dst_w    = data[DIM_W-1:0];
            CFG_DST_HEIGHT: dst_h    = data[DIM_W-1:0];
            CFG_STEP_X:     step_x_r = data[ACC_W-1:0];
            CFG_STEP_Y:     step_y_r = data[ACC_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy);
        drain();
        write_reg(CFG_DST_WIDTH, w);
        write_reg(CFG_DST_HEIGHT, h);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
    endtask

    // 1x1 target after reset: every fetch ends the frame and reads the origin
    task automatic test_reset_values();
        send_word(FUNC_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        fetch_pixel();
        send_word(FUNC_WRITE, 8'd255, 8'd255, 32'h0);
        send_word(FUNC_WRITE, 8'd0, 8'd0, 32'h0);
        fetch_pixel();
        fetch_pixel();
    endtask

    task automatic test_upscale_2x();
        configure(25'd4, 25'd2, 25'd32769, 25'd32769);
        repeat (8) fetch_pixel();
    endtask

    // max steps: accumulators saturate, source index clamps to the last row/col
    task automatic test_saturation();
        configure(25'd3, 25'd3, '1, '1);
        repeat (9) fetch_pixel();
    endtask

    task automatic test_size_limits();
        configure(25'd0, 25'd0, 25'd0, 25'd0);
        repeat (2) fetch_pixel();
        configure(25'd8191, 25'd8191, 25'd0, 25'd65537);
        repeat (3) fetch_pixel();
        // shrink width below the current column: row ends on the next word
        drain();
        write_reg(CFG_DST_WIDTH, 25'h1FFE002);
        fetch_pixel();
        drain();
        write_reg(CFG_DST_HEIGHT, 25'd1);
        write_reg(CFG_NO_REG, CFG_DATA_W'($urandom()));
        repeat (2) fetch_pixel();
        configure({12'd0, DIM_MAX}, {12'd0, DIM_MAX}, 25'd1, 25'd16777217);
        repeat (3) fetch_pixel();
    endtask

    task automatic test_output_stall();
        configure(25'd16, 25'd16, 25'd65537, 25'd65537);
        steady      = 1'b1;
        rx_hold_req = 1'b1;
        repeat (40) fetch_pixel();
        steady = 1'b0;
        drain();
    endtask

    task automatic test_random_traffic();
        int phase_len;
        logic [ACC_W-1:0] w;
        logic [ACC_W-1:0] h;
        while (words_sent < TOTAL_WORDS) begin
            w = rand_dim_val();
            h = rand_dim_val();
            configure(w, h, rand_step(w), rand_step(h));
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 90);
            for (int k = 0; k < phase_len && words_sent < TOTAL_WORDS; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(FUNC_WRITE, 8'($urandom()), 8'($urandom()), $urandom());
                else
                    fetch_pixel();
                if ($urandom_range(0, 59) == 0) drain();
            end
        end
        steady = 1'b0;
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_upscale_2x();
        test_saturation();
        test_size_limits();
        test_output_stall();
        test_random_traffic();
        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // output side: random stalls plus one long hold-off on request
    initial begin
        int hold;
        int pause;
        hold  = 0;
        pause = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold        = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (pause > 0) begin
                pause--;
                i_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                pause = idle_len() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected word pixel %h eor %b eof %b", $time,
                         o_out_pixel, o_end_of_row, o_end_of_frame);
                errors++;
            end else begin
                head_px = expected_px.pop_front();
                if (o_out_pixel !== head_px.pixel) begin
                    $display("%0t: out_pixel expected %h actual %h", $time,
                             head_px.pixel, o_out_pixel);
                    errors++;
                end
                if (o_end_of_row !== head_px.eor) begin
                    $display("%0t: end_of_row expected %b actual %b", $time,
                             head_px.eor, o_end_of_row);
                    errors++;
                end
                if (o_end_of_frame !== head_px.eof) begin
                    $display("%0t: end_of_frame expected %b actual %b", $time,
                             head_px.eof, o_end_of_frame);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, expected_px.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule

/* files.f */
rtl/nnis_pkg.sv
rtl/nnis_ram.sv
rtl/nnis_queue.sv
rtl/nnis_front.sv
rtl/nnis_back.sv
rtl/nearest_neighbor_image_scaler_unit.sv
tb/sv/nearest_neighbor_image_scaler_unit_tb.sv
